>>> rtl/mrcc_pkg.sv
package mrcc_pkg;

    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam int          WORD_BASE     = 3;
    localparam int          COUNT_MAX     = 511;
    localparam int          RESULT_MAX    = 8;
    localparam int          DEF_MAX_WORDS = 8;
    localparam logic [3:0]  REG_COUNT_RST = 4'd8;

    typedef enum logic [1:0] {
        ST_WORD  = 2'd0,
        ST_CRC   = 2'd1,
        ST_SHORT = 2'd2
    } t_status;

    typedef struct packed {
        t_status    status;
        logic [3:0] count;
    } t_job;

    typedef struct packed {
        logic        en;
        logic        bank;
        logic [7:0]  idx;
        logic [15:0] data;
    } t_wr;

    typedef struct packed {
        logic bank_wr;
        logic bank_rd;
        logic full;
        logic valid;
        t_job head;
    } t_qstat;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_FETCH,
        BS_WORD,
        BS_ERR
    } t_bstate;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        int          k;
        c = crc ^ {8'h00, b};
        for (k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> rtl/mrcc_front.sv
module mrcc_front #(
    parameter int MAX_WORDS = mrcc_pkg::DEF_MAX_WORDS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_frame_end,
    input  logic             i_cfg_wr_en,
    input  logic [3:0]       i_cfg_wr_data,
    input  mrcc_pkg::t_qstat i_qstat,
    output logic             o_full,
    output logic             o_job_push,
    output mrcc_pkg::t_job   o_job,
    output mrcc_pkg::t_wr    o_wr
);

    localparam int STORE_WORDS = (MAX_WORDS < mrcc_pkg::RESULT_MAX) ?
                                 MAX_WORDS : mrcc_pkg::RESULT_MAX;
    localparam logic [3:0] N_MAX = 4'(STORE_WORDS);

    logic [3:0]  r_reg_count;
    logic [15:0] r_crc, n_crc;
    logic [8:0]  r_byte_count, n_byte_count;
    logic [15:0] r_tail, n_tail;
    logic [7:0]  r_high, n_high;

    logic        accept;
    logic [8:0]  rel;
    logic [7:0]  word_idx;
    logic        in_words;
    logic [3:0]  eff_count;
    logic [8:0]  need;
    logic [15:0] rx_crc;

    assign accept = i_push & ~i_qstat.full;
    assign o_full = i_qstat.full;

    always_comb begin
        n_crc = (r_byte_count >= 9'd2) ? mrcc_pkg::crc_feed(r_crc, r_tail[15:8]) : r_crc;
        rel      = r_byte_count - 9'(mrcc_pkg::WORD_BASE);
        word_idx = rel[8:1];
        in_words = (r_byte_count >= 9'(mrcc_pkg::WORD_BASE)) &&
                   (word_idx < 8'(STORE_WORDS));
        n_tail = {r_tail[7:0], i_rx_byte};
        n_byte_count = (r_byte_count != 9'(mrcc_pkg::COUNT_MAX)) ?
                       r_byte_count + 9'd1 : r_byte_count;
        n_high = (in_words && !rel[0]) ? i_rx_byte : r_high;

        o_wr.en   = accept && in_words && rel[0];
        o_wr.bank = i_qstat.bank_wr;
        o_wr.idx  = word_idx;
        o_wr.data = {r_high, i_rx_byte};

        if (r_reg_count == 4'd0) begin
            eff_count = 4'd1;
        end else if (r_reg_count > N_MAX) begin
            eff_count = N_MAX;
        end else begin
            eff_count = r_reg_count;
        end
        need   = 9'({eff_count, 1'b0}) + 9'(mrcc_pkg::WORD_BASE + 2);
        rx_crc = {i_rx_byte, r_tail[7:0]};

        o_job.count = eff_count;
        if (n_byte_count < need) begin
            o_job.status = mrcc_pkg::ST_SHORT;
        end else if (n_crc != rx_crc) begin
            o_job.status = mrcc_pkg::ST_CRC;
        end else begin
            o_job.status = mrcc_pkg::ST_WORD;
        end
        o_job_push = accept & i_frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_count  <= mrcc_pkg::REG_COUNT_RST;
            r_crc        <= mrcc_pkg::CRC_INIT;
            r_byte_count <= '0;
            r_tail       <= '0;
            r_high       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_reg_count <= i_cfg_wr_data;
            end
            if (accept) begin
                if (i_frame_end) begin
                    r_crc        <= mrcc_pkg::CRC_INIT;
                    r_byte_count <= '0;
                    r_tail       <= '0;
                    r_high       <= '0;
                end else begin
                    r_crc        <= n_crc;
                    r_byte_count <= n_byte_count;
                    r_tail       <= n_tail;
                    r_high       <= n_high;
                end
            end
        end
    end

endmodule

>>> rtl/mrcc_queue.sv
module mrcc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mrcc_pkg::t_job   i_job,
    input  logic             i_pop,
    output mrcc_pkg::t_qstat o_qstat
);

    mrcc_pkg::t_job r_job [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    always_comb begin
        o_qstat.bank_wr = r_wr_ptr;
        o_qstat.bank_rd = r_rd_ptr;
        o_qstat.full    = (r_count == 2'd2);
        o_qstat.valid   = (r_count != 2'd0);
        o_qstat.head    = r_job[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_job[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/mrcc_wstore.sv
module mrcc_wstore #(
    parameter int MAX_WORDS = mrcc_pkg::DEF_MAX_WORDS
) (
    input  logic          i_clk,
    input  mrcc_pkg::t_wr i_wr,
    input  logic          i_rd_bank,
    input  logic [2:0]    i_rd_idx,
    output logic [15:0]   o_rd_data
);

    localparam int STORE_WORDS = (MAX_WORDS < mrcc_pkg::RESULT_MAX) ?
                                 MAX_WORDS : mrcc_pkg::RESULT_MAX;
    localparam int IDX_W = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int DEPTH = 2 * (2 ** IDX_W);

    logic [15:0] mem [DEPTH];
    logic [15:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[{i_wr.bank, i_wr.idx[IDX_W-1:0]}] <= i_wr.data;
        end
        r_rd_data <= mem[{i_rd_bank, i_rd_idx[IDX_W-1:0]}];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/mrcc_back.sv
module mrcc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mrcc_pkg::t_qstat i_qstat,
    input  logic [15:0]      i_rd_data,
    input  logic             i_pop,
    output logic [2:0]       o_rd_idx,
    output logic             o_job_pop,
    output logic             o_empty,
    output logic [1:0]       o_status,
    output logic [2:0]       o_reg_index,
    output logic [15:0]      o_reg_value,
    output logic             o_last
);

    mrcc_pkg::t_bstate r_state, n_state;
    logic [2:0]        r_idx, n_idx;
    logic              word_last;

    assign o_rd_idx  = r_idx;
    assign word_last = ({1'b0, r_idx} + 4'd1) == i_qstat.head.count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mrcc_pkg::BS_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        o_job_pop   = 1'b0;
        o_empty     = 1'b1;
        o_status    = mrcc_pkg::ST_WORD;
        o_reg_index = '0;
        o_reg_value = '0;
        o_last      = 1'b0;
        case (r_state)
            mrcc_pkg::BS_IDLE: begin
                if (i_qstat.valid) begin
                    if (i_qstat.head.status == mrcc_pkg::ST_WORD) begin
                        n_idx   = '0;
                        n_state = mrcc_pkg::BS_FETCH;
                    end else begin
                        n_state = mrcc_pkg::BS_ERR;
                    end
                end
            end
            mrcc_pkg::BS_FETCH: begin
                n_state = mrcc_pkg::BS_WORD;
            end
            mrcc_pkg::BS_WORD: begin
                o_empty     = 1'b0;
                o_reg_index = r_idx;
                o_reg_value = i_rd_data;
                o_last      = word_last;
                if (i_pop) begin
                    if (word_last) begin
                        o_job_pop = 1'b1;
                        n_state   = mrcc_pkg::BS_IDLE;
                    end else begin
                        n_idx   = r_idx + 3'd1;
                        n_state = mrcc_pkg::BS_FETCH;
                    end
                end
            end
            mrcc_pkg::BS_ERR: begin
                o_empty  = 1'b0;
                o_status = i_qstat.head.status;
                o_last   = 1'b1;
                if (i_pop) begin
                    o_job_pop = 1'b1;
                    n_state   = mrcc_pkg::BS_IDLE;
                end
            end
            default: begin
                n_state = mrcc_pkg::BS_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/modbus_response_crc_checker.sv
// Channel   Direction  Transfer when      Payload
// input     in         push && !full      i_rx_byte, i_frame_end
// result    out        pop && !empty      o_status, o_reg_index, o_reg_value, o_last
// config    in         i_cfg_wr_en        i_cfg_wr_data (reg_count)
//
// Frame bytes are taken at one per cycle while full is low; the CRC byte step is done in the accept cycle.
// A good frame is delivered in steps: BS_IDLE picks up the finished frame, then each word
// passes BS_FETCH, waiting for the word store's registered read port, and BS_WORD, which
// offers it until it is popped. An error result passes BS_IDLE and then BS_ERR.
// Up to two finished frames wait for delivery, each with its own word store bank, and
// full stays high while both are held. Reset is synchronous and clears the frame state.
module modbus_response_crc_checker #(
    parameter int MAX_WORDS = mrcc_pkg::DEF_MAX_WORDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_frame_end,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_status,
    output logic [2:0]  o_reg_index,
    output logic [15:0] o_reg_value,
    output logic        o_last,
    input  logic        i_cfg_wr_en,
    input  logic [3:0]  i_cfg_wr_data
);

    mrcc_pkg::t_qstat qstat;
    mrcc_pkg::t_job   job;
    mrcc_pkg::t_wr    wr;
    logic             job_push;
    logic             job_pop;
    logic [2:0]       rd_idx;
    logic [15:0]      rd_data;

    mrcc_front #(
        .MAX_WORDS(MAX_WORDS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_rx_byte    (i_rx_byte),
        .i_frame_end  (i_frame_end),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_qstat      (qstat),
        .o_full       (full),
        .o_job_push   (job_push),
        .o_job        (job),
        .o_wr         (wr)
    );

    mrcc_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (job_push),
        .i_job  (job),
        .i_pop  (job_pop),
        .o_qstat(qstat)
    );

    mrcc_wstore #(
        .MAX_WORDS(MAX_WORDS)
    ) u_wstore (
        .i_clk    (i_clk),
        .i_wr     (wr),
        .i_rd_bank(qstat.bank_rd),
        .i_rd_idx (rd_idx),
        .o_rd_data(rd_data)
    );

    mrcc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_qstat    (qstat),
        .i_rd_data  (rd_data),
        .i_pop      (pop),
        .o_rd_idx   (rd_idx),
        .o_job_pop  (job_pop),
        .o_empty    (empty),
        .o_status   (o_status),
        .o_reg_index(o_reg_index),
        .o_reg_value(o_reg_value),
        .o_last     (o_last)
    );

endmodule

>>> rtl/mrcc_checker.sv
module mrcc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  o_status,
    input logic [2:0]  o_reg_index,
    input logic [15:0] o_reg_value,
    input logic        o_last
);

    // An error result is always the single, last result of its frame.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != mrcc_pkg::ST_WORD) |-> (o_last && o_reg_value == 16'd0 &&
        o_reg_index == 3'd0))
        else $error("error result is not a lone zeroed last result");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_status == mrcc_pkg::ST_WORD || o_status == mrcc_pkg::ST_CRC ||
        o_status == mrcc_pkg::ST_SHORT))
        else $error("undefined status code");

    // After a non-final word transfer the following word of the same frame comes next.
    a_word_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_last && o_status == mrcc_pkg::ST_WORD) |->
        ##2 (!empty && o_reg_index == $past(o_reg_index, 2) + 3'd1))
        else $error("register words out of sequence");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_reg_value) && $stable(o_status) &&
        $stable(o_last)))
        else $error("waiting result changed");

endmodule

bind modbus_response_crc_checker mrcc_checker u_mrcc_checker (.*);

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    typedef struct {
        logic [7:0] data;
        logic       fin;
    } t_rx_item;

    typedef struct {
        mrcc_pkg::t_status status;
        logic [2:0]        index;
        logic [15:0]       value;
        logic              fin;
    } t_reg_word;

    typedef enum {
        FR_GOOD,
        FR_BAD_CRC,
        FR_RAW
    } t_frame_kind;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_frame_end = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  o_status;
    logic [2:0]  o_reg_index;
    logic [15:0] o_reg_value;
    logic        o_last;
    logic        i_cfg_wr_en = 1'b0;
    logic [3:0]  i_cfg_wr_data = 4'd0;

    t_rx_item  rx_bytes_q[$];
    t_reg_word reg_words_q[$];
    t_rx_item  tx_item;

    logic        in_fire = 1'b0;
    logic        out_fire = 1'b0;
    logic        tx_idle_en = 1'b1;
    logic        rx_idle_en = 1'b1;
    int          tx_wait = 0;
    int          rx_wait = 0;
    int          hold_req = 0;
    int          hold_served = 0;

    logic [3:0]  words_cfg = mrcc_pkg::REG_COUNT_RST;
    logic [15:0] frame_crc;
    int          frame_len;
    logic [15:0] tail_pair;
    logic [15:0] word_mem[mrcc_pkg::DEF_MAX_WORDS];
    logic [7:0]  pend_high;

    logic [3:0]  cfg_now = mrcc_pkg::REG_COUNT_RST;
    int          bytes_queued = 0;
    int          bytes_taken = 0;
    int          frames_sent = 0;
    int          results_seen = 0;
    int          cfg_writes = 0;
    int          fail_count = 0;

    modbus_response_crc_checker u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_rx_byte    (i_rx_byte),
        .i_frame_end  (i_frame_end),
        .empty        (empty),
        .pop          (pop),
        .o_status     (o_status),
        .o_reg_index  (o_reg_index),
        .o_reg_value  (o_reg_value),
        .o_last       (o_last),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] v;
        v = acc ^ {8'h00, b};
        repeat (8) begin
            if (v[0]) begin
                v = (v >> 1) ^ mrcc_pkg::CRC_POLY;
            end else begin
                v = v >> 1;
            end
        end
        return v;
    endfunction

    function automatic int unsigned words_wanted(input logic [3:0] cfg);
        int unsigned n;
        n = (cfg == 4'd0) ? 1 : cfg;
        if (n > mrcc_pkg::RESULT_MAX) begin
            n = mrcc_pkg::RESULT_MAX;
        end
        if (n > mrcc_pkg::DEF_MAX_WORDS) begin
            n = mrcc_pkg::DEF_MAX_WORDS;
        end
        return n;
    endfunction

    function automatic int unsigned frame_need(input logic [3:0] cfg);
        return 2 * words_wanted(cfg) + mrcc_pkg::WORD_BASE + 2;
    endfunction

    task automatic clear_frame_state();
        frame_crc = mrcc_pkg::CRC_INIT;
        frame_len = 0;
        tail_pair = 16'h0000;
        pend_high = 8'h00;
    endtask

    task automatic take_rx_byte(input logic [7:0] b, input logic fin);
        int unsigned pos;
        int unsigned rel;
        int unsigned n;
        logic [15:0] rx_crc;
        t_reg_word   w;
        pos = frame_len;
        if (pos >= 2) begin
            frame_crc = crc16_byte(frame_crc, tail_pair[15:8]);
        end
        if (pos >= mrcc_pkg::WORD_BASE) begin
            rel = pos - mrcc_pkg::WORD_BASE;
            if ((rel >> 1) < mrcc_pkg::DEF_MAX_WORDS) begin
                if (rel[0] == 1'b0) begin
                    pend_high = b;
                end else begin
                    word_mem[rel >> 1] = {pend_high, b};
                end
            end
        end
        tail_pair = {tail_pair[7:0], b};
        if (frame_len < mrcc_pkg::COUNT_MAX) begin
            frame_len++;
        end
        if (fin) begin
            n = words_wanted(words_cfg);
            rx_crc = {tail_pair[7:0], tail_pair[15:8]};
            if (frame_len < frame_need(words_cfg) || frame_crc != rx_crc) begin
                w.status = (frame_len < frame_need(words_cfg)) ? mrcc_pkg::ST_SHORT :
                                                                 mrcc_pkg::ST_CRC;
                w.index = 3'd0;
                w.value = 16'h0000;
                w.fin = 1'b1;
                reg_words_q.push_back(w);
            end else begin
                for (int i = 0; i < n; i++) begin
                    w.status = mrcc_pkg::ST_WORD;
                    w.index = i[2:0];
                    w.value = word_mem[i];
                    w.fin = (i + 1 == n);
                    reg_words_q.push_back(w);
                end
            end
            clear_frame_state();
        end
    endtask

    task automatic check_reg_word();
        t_reg_word w;
        results_seen++;
        if (reg_words_q.size() == 0) begin
            $error("unexpected result: status %0d index %0d value %h last %0b",
                   o_status, o_reg_index, o_reg_value, o_last);
            fail_count++;
        end else begin
            w = reg_words_q.pop_front();
            if (o_status !== w.status) begin
                $error("status: expected %0d, actual %0d", w.status, o_status);
                fail_count++;
            end
            if (o_reg_index !== w.index) begin
                $error("reg_index: expected %0d, actual %0d", w.index, o_reg_index);
                fail_count++;
            end
            if (o_reg_value !== w.value) begin
                $error("reg_value: expected %h, actual %h", w.value, o_reg_value);
                fail_count++;
            end
            if (o_last !== w.fin) begin
                $error("last: expected %0b, actual %0b", w.fin, o_last);
                fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_fire <= 1'b0;
            out_fire <= 1'b0;
            words_cfg = mrcc_pkg::REG_COUNT_RST;
            clear_frame_state();
        end else begin
            in_fire <= push && !full;
            out_fire <= pop && !empty;
            if (i_cfg_wr_en) begin
                words_cfg = i_cfg_wr_data;
            end
            if (push && !full) begin
                take_rx_byte(i_rx_byte, i_frame_end);
                bytes_taken++;
            end
            if (pop && !empty) begin
                check_reg_word();
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!(push && !in_fire)) begin
            if (tx_wait > 0) begin
                push <= 1'b0;
                tx_wait--;
            end else if (rx_bytes_q.size() > 0) begin
                tx_item = rx_bytes_q.pop_front();
                i_rx_byte <= tx_item.data;
                i_frame_end <= tx_item.fin;
                push <= 1'b1;
                tx_wait = tx_idle_en ? $urandom_range(0, 5) : 0;
            end else begin
                push <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (out_fire) begin
                rx_wait = rx_idle_en ? $urandom_range(0, 5) : 0;
            end
            if (hold_served < hold_req) begin
                hold_served++;
                rx_wait = 400;
            end
            if (rx_wait > 0) begin
                pop <= 1'b0;
                rx_wait--;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    task automatic queue_byte(input logic [7:0] b, input logic fin);
        t_rx_item it;
        it.data = b;
        it.fin = fin;
        rx_bytes_q.push_back(it);
        bytes_queued++;
    endtask

    task automatic add_frame(input t_frame_kind kind, input int len, input logic rnd,
                             input logic [7:0] fill);
        logic [7:0]  bytes[$];
        logic [15:0] crc;
        int          body;
        int          pick;
        crc = mrcc_pkg::CRC_INIT;
        body = (kind == FR_RAW) ? len : len - 2;
        for (int i = 0; i < body; i++) begin
            bytes.push_back(rnd ? 8'($urandom) : fill);
            crc = crc16_byte(crc, bytes[i]);
        end
        if (kind != FR_RAW) begin
            bytes.push_back(crc[7:0]);
            bytes.push_back(crc[15:8]);
        end
        if (kind == FR_BAD_CRC) begin
            pick = $urandom_range(0, len - 1);
            bytes[pick] = bytes[pick] ^ (8'h01 << $urandom_range(0, 7));
        end
        for (int i = 0; i < len; i++) begin
            queue_byte(bytes[i], i == len - 1);
        end
        frames_sent++;
    endtask

    task automatic add_random_frames(input int budget);
        int target;
        int sel;
        int need;
        target = bytes_queued + budget;
        need = frame_need(cfg_now);
        while (bytes_queued < target) begin
            sel = $urandom_range(0, 99);
            if (sel < 10) begin
                add_frame(FR_GOOD, need + $urandom_range(0, 20), 1'b1, 8'h00);
            end else if (sel < 65) begin
                add_frame(FR_GOOD, need + $urandom_range(0, 3), 1'b1, 8'h00);
            end else if (sel < 78) begin
                add_frame(FR_BAD_CRC, need + $urandom_range(0, 2), 1'b1, 8'h00);
            end else if (sel < 92) begin
                add_frame(FR_RAW, $urandom_range(1, need - 1), 1'b1, 8'h00);
            end else begin
                add_frame(FR_RAW, need + $urandom_range(0, 4), 1'b1, 8'h00);
            end
        end
    endtask

    task automatic wait_drained();
        while (bytes_taken != bytes_queued || reg_words_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (12) @(negedge i_clk);
    endtask

    task automatic write_word_count(input logic [3:0] v);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cfg_now = v;
        cfg_writes++;
    endtask

    task automatic run_phase(input logic [3:0] cfg, input int budget, input logic tx_idle,
                             input logic rx_idle);
        write_word_count(cfg);
        tx_idle_en = tx_idle;
        rx_idle_en = rx_idle;
        add_random_frames(budget);
        wait_drained();
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Short directed frames with one word per response.
        write_word_count(4'd1);
        add_frame(FR_GOOD, 7, 1'b0, 8'hFF);
        add_frame(FR_GOOD, 7, 1'b0, 8'h00);
        add_frame(FR_BAD_CRC, 7, 1'b1, 8'h00);
        add_frame(FR_RAW, 1, 1'b1, 8'h00);
        add_frame(FR_GOOD, 4, 1'b1, 8'h00);
        wait_drained();

        // The receiver stalls long enough here for the input side to fill up.
        hold_req++;
        run_phase(4'd0, 30, 1'b0, 1'b1);

        // A long 260-byte frame must still pass.
        write_word_count(4'd15);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        add_frame(FR_GOOD, 260, 1'b1, 8'h00);
        add_random_frames(10);
        wait_drained();

        run_phase(4'd8, 20, 1'b1, 1'b1);
        run_phase(4'd3, 20, 1'b1, 1'b0);
        run_phase(4'd5, 20, 1'b1, 1'b1);
        run_phase(4'd10, 20, 1'b0, 1'b0);
        run_phase(4'($urandom_range(1, 8)), 20, 1'b1, 1'b1);

        $display("Run covered %0d frames (%0d bytes) and %0d results under %0d word counts.",
                 frames_sent, bytes_queued, results_seen, cfg_writes);
        if (fail_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
